### rtl/mahp_pkg.sv
// Package with the types, constants and lookup functions of the MPEG audio header parser.
`timescale 1ns / 1ps
package mahp_pkg;

    localparam int DivNumW = 35;
    localparam int DivDenW = 19;
    localparam int DivCntW = 6;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LAYER = 3'd1,
        ST_BAD_RATE  = 3'd2,
        ST_BAD_FREQ  = 3'd3,
        ST_BAD_EMPH  = 3'd4
    } status_t;

    // One header handed from the byte parser to the arithmetic side.
    typedef struct packed {
        status_t     status;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
    } hdr_t;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [8:0] kbps_lookup(input logic [2:0] row, input logic [3:0] idx);
        logic [8:0] r;
        r = 9'd0;
        case (row)
            3'd0: case (idx)
                4'd1: r = 9'd32;  4'd2: r = 9'd64;  4'd3: r = 9'd96;  4'd4: r = 9'd128;
                4'd5: r = 9'd160; 4'd6: r = 9'd192; 4'd7: r = 9'd224; 4'd8: r = 9'd256;
                4'd9: r = 9'd288; 4'd10: r = 9'd320; 4'd11: r = 9'd352; 4'd12: r = 9'd384;
                4'd13: r = 9'd416; 4'd14: r = 9'd448; default: r = 9'd0;
            endcase
            3'd1: case (idx)
                4'd1: r = 9'd32;  4'd2: r = 9'd48;  4'd3: r = 9'd56;  4'd4: r = 9'd64;
                4'd5: r = 9'd80;  4'd6: r = 9'd96;  4'd7: r = 9'd112; 4'd8: r = 9'd128;
                4'd9: r = 9'd160; 4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
                4'd13: r = 9'd320; 4'd14: r = 9'd384; default: r = 9'd0;
            endcase
            3'd2: case (idx)
                4'd1: r = 9'd32;  4'd2: r = 9'd40;  4'd3: r = 9'd48;  4'd4: r = 9'd56;
                4'd5: r = 9'd64;  4'd6: r = 9'd80;  4'd7: r = 9'd96;  4'd8: r = 9'd112;
                4'd9: r = 9'd128; 4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
                4'd13: r = 9'd256; 4'd14: r = 9'd320; default: r = 9'd0;
            endcase
            3'd3: case (idx)
                4'd1: r = 9'd32;  4'd2: r = 9'd48;  4'd3: r = 9'd56;  4'd4: r = 9'd64;
                4'd5: r = 9'd80;  4'd6: r = 9'd96;  4'd7: r = 9'd112; 4'd8: r = 9'd128;
                4'd9: r = 9'd144; 4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
                4'd13: r = 9'd224; 4'd14: r = 9'd256; default: r = 9'd0;
            endcase
            default: case (idx)
                4'd1: r = 9'd8;   4'd2: r = 9'd16;  4'd3: r = 9'd24;  4'd4: r = 9'd32;
                4'd5: r = 9'd40;  4'd6: r = 9'd48;  4'd7: r = 9'd56;  4'd8: r = 9'd64;
                4'd9: r = 9'd80;  4'd10: r = 9'd96; 4'd11: r = 9'd112; 4'd12: r = 9'd128;
                4'd13: r = 9'd144; 4'd14: r = 9'd160; default: r = 9'd0;
            endcase
        endcase
        return r;
    endfunction

    function automatic logic [15:0] base_rate(input logic [1:0] idx);
        logic [15:0] r;
        case (idx)
            2'd0:    r = 16'd44100;
            2'd1:    r = 16'd48000;
            2'd2:    r = 16'd32000;
            default: r = 16'd44100;
        endcase
        return r;
    endfunction

endpackage

### rtl/mahp_front.sv
// Byte parser: sync hunt, header checks, and hand-off of each finished header.
`timescale 1ns / 1ps
module mahp_front import mahp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    output logic       push,
    output hdr_t       push_hdr
);

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_SYNC  = 4'b0010,
        PH_BYTE2 = 4'b0100,
        PH_BYTE3 = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] b2_reg, b2_next;
    logic [7:0] b3_reg, b3_next;
    phase_t     resync;
    logic       bad_vl;

    always_comb
    begin
        phase_next = phase_reg;
        b2_next    = b2_reg;
        b3_next    = b3_reg;
        push       = 1'b0;
        push_hdr   = '{status: ST_OK, byte2: b2_reg, byte3: b3_reg, byte4: data_byte};
        resync     = (data_byte == 8'hFF) ? PH_SYNC : PH_HUNT;
        // Reserved version, reserved layer, or MPEG-2.5 with a layer other than III.
        bad_vl = (data_byte[4:3] == 2'b01) || (data_byte[2:1] == 2'b00) ||
                 ((data_byte[4:3] == 2'b00) && (data_byte[2:1] != 2'b01));
        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == 8'hFF)
                        phase_next = PH_SYNC;
                end
                PH_SYNC:
                begin
                    if (data_byte[7:5] != 3'b111)
                        phase_next = PH_HUNT;
                    else if (bad_vl)
                    begin
                        push            = 1'b1;
                        push_hdr.status = ST_BAD_LAYER;
                        phase_next      = resync;
                    end
                    else
                    begin
                        b2_next    = data_byte;
                        phase_next = PH_BYTE2;
                    end
                end
                PH_BYTE2:
                begin
                    if ((data_byte[7:4] == 4'h0) || (data_byte[7:4] == 4'hF))
                    begin
                        push            = 1'b1;
                        push_hdr.status = ST_BAD_RATE;
                        phase_next      = resync;
                    end
                    else if (data_byte[3:2] == 2'b11)
                    begin
                        push            = 1'b1;
                        push_hdr.status = ST_BAD_FREQ;
                        phase_next      = resync;
                    end
                    else
                    begin
                        b3_next    = data_byte;
                        phase_next = PH_BYTE3;
                    end
                end
                PH_BYTE3:
                begin
                    push = 1'b1;
                    if (data_byte[1:0] == 2'b10)
                    begin
                        push_hdr.status = ST_BAD_EMPH;
                        phase_next      = resync;
                    end
                    else
                        phase_next = PH_HUNT;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            b2_reg    <= 8'd0;
            b3_reg    <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            b2_reg    <= b2_next;
            b3_reg    <= b3_next;
        end
    end

endmodule

### rtl/mahp_queue.sv
// Two-entry header queue between the byte parser and the arithmetic side.
`timescale 1ns / 1ps
module mahp_queue import mahp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  hdr_t    push_hdr,
    input  logic    pop,
    output hdr_t    pop_hdr,
    output q_stat_t stat
);

    hdr_t       mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_hdr    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= push_hdr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) stat.full |-> !(cnt_next > 2'd2);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue count overflow");

    property p_pop_empty;
        @(posedge clk) disable iff (!rst_n) (stat.empty && !push) |=> stat.empty;
    endproperty
    a_pop_empty: assert property (p_pop_empty) else $error("queue drained below empty");

    property p_count_step;
        @(posedge clk) disable iff (!rst_n) (do_push && !do_pop) |=> !stat.empty;
    endproperty
    a_count_step: assert property (p_count_step) else $error("queue lost a pushed entry");

endmodule

### rtl/mahp_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module mahp_div import mahp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DivNumW-1:0] dividend,
    input  logic [DivDenW-1:0] divisor,
    output logic               done,
    output logic [DivNumW-1:0] quotient
);

    logic [DivNumW-1:0] q_reg, q_next;
    logic [DivDenW:0]   rem_reg, rem_next;
    logic [DivDenW-1:0] den_reg, den_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DivDenW:0]   trial;

    assign done     = done_reg;
    assign quotient = q_reg;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DivDenW-1:0], q_reg[DivNumW-1]};
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = DivCntW'(DivNumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[DivNumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[DivNumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DivCntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

### rtl/mahp_back.sv
// Header decoder: field tables, frame length, frame count and playing time, output register.
`timescale 1ns / 1ps
module mahp_back import mahp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  hdr_t        q_hdr,
    output logic        pop,
    input  logic [31:0] stream_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  version,
    output logic [1:0]  layer,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic [10:0] frame_bytes,
    output logic [1:0]  channel_mode,
    output logic        copyright_flag,
    output logic        original_flag,
    output logic [1:0]  emphasis,
    output logic [31:0] frame_count,
    output logic [22:0] play_seconds
);

    typedef enum logic [8:0] {
        B_IDLE      = 9'b000000001,
        B_MUL       = 9'b000000010,
        B_LEN_GO    = 9'b000000100,
        B_LEN_WAIT  = 9'b000001000,
        B_CNT_GO    = 9'b000010000,
        B_CNT_WAIT  = 9'b000100000,
        B_PLAY_GO   = 9'b001000000,
        B_PLAY_WAIT = 9'b010000000,
        B_OUT       = 9'b100000000
    } bstate_t;

    bstate_t     st_reg, st_next;
    logic [2:0]  status_reg;
    logic [1:0]  ver_reg, lay_reg, mode_reg, emph_reg;
    logic [8:0]  br_reg;
    logic [15:0] sr_reg;
    logic        pad_reg, copy_reg, orig_reg;
    logic [18:0] num_reg;
    logic [10:0] len_reg;
    logic [31:0] cnt_reg;
    logic [22:0] play_reg;

    logic [1:0]  d_ver, d_lay;
    logic [2:0]  d_row;
    logic [8:0]  d_br;
    logic [15:0] d_base;
    logic        div_start, div_done;
    logic [DivNumW-1:0] div_num, div_q;
    logic [DivDenW-1:0] div_den;
    logic [25:0] len_num;
    logic [10:0] len_calc;

    // Decode version and layer of header byte two, bit rate and base rate of byte three.
    always_comb
    begin
        case (q_hdr.byte2[4:3])
            2'b11:   d_ver = 2'd0;
            2'b10:   d_ver = 2'd1;
            2'b00:   d_ver = 2'd2;
            default: d_ver = 2'd0;
        endcase
        d_lay = 2'd0 - q_hdr.byte2[2:1];
        if (d_lay == 2'd0)
            d_lay = 2'd3;
        if (d_ver == 2'd0)
            d_row = {1'b0, d_lay - 2'd1};
        else
            d_row = (d_lay == 2'd1) ? 3'd3 : 3'd4;
        d_br = kbps_lookup(d_row, q_hdr.byte3[7:4]);
        if (d_br == 9'd0)
            d_br = 9'd32;
        d_base = base_rate(q_hdr.byte3[3:2]);
    end

    // Frame length numerator: 12, 72 or 144 times the bit rate in bits per second.
    always_comb
    begin
        if (lay_reg == 2'd1)
            len_num = {7'd0, num_reg} * 26'd12;
        else if ((lay_reg == 2'd3) && (ver_reg != 2'd0))
            len_num = {7'd0, num_reg} * 26'd72;
        else
            len_num = {7'd0, num_reg} * 26'd144;
        if (lay_reg == 2'd1)
            len_calc = 11'({div_q[8:0] + {8'd0, pad_reg}, 2'b00});
        else
            len_calc = 11'(div_q[10:0] + {10'd0, pad_reg});
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (st_reg)
            B_LEN_GO:
            begin
                div_start = 1'b1;
                div_num   = DivNumW'(len_num);
                div_den   = DivDenW'(sr_reg);
            end
            B_CNT_GO:
            begin
                div_start = 1'b1;
                div_num   = DivNumW'(stream_length);
                div_den   = DivDenW'(len_reg);
            end
            B_PLAY_GO:
            begin
                div_start = 1'b1;
                div_num   = {stream_length, 3'b000};
                div_den   = num_reg;
            end
            default: ;
        endcase
    end

    mahp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        st_next = st_reg;
        pop     = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop     = 1'b1;
                    st_next = (q_hdr.status == ST_OK) ? B_MUL : B_OUT;
                end
            end
            B_MUL:       st_next = B_LEN_GO;
            B_LEN_GO:    st_next = B_LEN_WAIT;
            B_LEN_WAIT:  if (div_done) st_next = B_CNT_GO;
            B_CNT_GO:    st_next = B_CNT_WAIT;
            B_CNT_WAIT:  if (div_done) st_next = B_PLAY_GO;
            B_PLAY_GO:   st_next = B_PLAY_WAIT;
            B_PLAY_WAIT: if (div_done) st_next = B_OUT;
            B_OUT:       if (!out_stall) st_next = B_IDLE;
            default:     st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == B_IDLE)
        begin
            status_reg <= q_hdr.status;
            if (q_hdr.status == ST_OK)
            begin
                ver_reg  <= d_ver;
                lay_reg  <= d_lay;
                br_reg   <= d_br;
                sr_reg   <= d_base >> d_ver;
                pad_reg  <= q_hdr.byte3[1];
                mode_reg <= q_hdr.byte4[7:6];
                copy_reg <= q_hdr.byte4[3];
                orig_reg <= q_hdr.byte4[2];
                emph_reg <= (q_hdr.byte4[1:0] == 2'b11) ? 2'd2 : q_hdr.byte4[1:0];
            end
            else
            begin
                ver_reg  <= '0;
                lay_reg  <= '0;
                br_reg   <= '0;
                sr_reg   <= '0;
                pad_reg  <= 1'b0;
                mode_reg <= '0;
                copy_reg <= 1'b0;
                orig_reg <= 1'b0;
                emph_reg <= '0;
                len_reg  <= '0;
                cnt_reg  <= '0;
                play_reg <= '0;
            end
        end
        if (st_reg == B_MUL)
            num_reg <= {10'd0, br_reg} * 19'd1000;
        if ((st_reg == B_LEN_WAIT) && div_done)
            len_reg <= len_calc;
        if ((st_reg == B_CNT_WAIT) && div_done)
            cnt_reg <= div_q[31:0];
        if ((st_reg == B_PLAY_WAIT) && div_done)
            play_reg <= div_q[22:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= B_IDLE;
        else
            st_reg <= st_next;
    end

    assign out_valid      = (st_reg == B_OUT);
    assign status         = status_reg;
    assign version        = ver_reg;
    assign layer          = lay_reg;
    assign bitrate_kbps   = br_reg;
    assign sample_rate_hz = sr_reg;
    assign frame_bytes    = len_reg;
    assign channel_mode   = mode_reg;
    assign copyright_flag = copy_reg;
    assign original_flag  = orig_reg;
    assign emphasis       = emph_reg;
    assign frame_count    = cnt_reg;
    assign play_seconds   = play_reg;

    property p_err_zero;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && (status != ST_OK)) |-> ((layer == 2'd0) && (bitrate_kbps == 9'd0)
                && (frame_bytes == 11'd0) && (frame_count == 32'd0));
    endproperty
    a_err_zero: assert property (p_err_zero) else $error("error result with nonzero fields");

    property p_ok_len;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && (status == ST_OK)) |-> ((frame_bytes != 11'd0) && (layer != 2'd0));
    endproperty
    a_ok_len: assert property (p_ok_len) else $error("good header without frame length");

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && out_stall) |=> (out_valid && $stable(frame_count));
    endproperty
    a_hold: assert property (p_hold) else $error("stalled result changed");

    property p_no_pop_busy;
        @(posedge clk) disable iff (!rst_n) pop |-> (st_reg == B_IDLE);
    endproperty
    a_no_pop_busy: assert property (p_no_pop_busy) else $error("queue popped while busy");

endmodule

### rtl/mpeg_audio_header_parser_unit.sv
// Top level of the MPEG audio frame header parser.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake             Payload
//  ------    ---------  --------------------  ------------------------------------------
//  input     in         in_valid / in_stall    data_byte
//  output    out        out_valid / out_stall  status ... play_seconds (twelve fields)
//  config    in         APB psel/penable       stream_length at byte address 0
//
//  The byte parser takes one byte per cycle while the header queue has room.
//  For each good header the arithmetic side dequeues, multiplies, then runs
//  three divisions on the shared one-bit-per-cycle divider (frame length,
//  frame count, playing time) and ends in the output state; an error header
//  goes from dequeue straight to output. When the two-entry queue fills,
//  in_stall rises until the arithmetic side frees an entry. A stalled result
//  holds in the output register. Reset clears the parse phase, queue pointers,
//  sequencer state and the stream length register.
//
module mpeg_audio_header_parser_unit import mahp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  version,
    output logic [1:0]  layer,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic [10:0] frame_bytes,
    output logic [1:0]  channel_mode,
    output logic        copyright_flag,
    output logic        original_flag,
    output logic [1:0]  emphasis,
    output logic [31:0] frame_count,
    output logic [22:0] play_seconds,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] stream_length_reg;
    logic        in_fire;
    logic        push, pop;
    hdr_t        push_hdr, pop_hdr;
    q_stat_t     q_stat;

    // Configuration register: written on the access phase of an APB transfer.
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? stream_length_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stream_length_reg <= 32'd0;
        else if (psel && penable && pwrite && (paddr == 3'd0))
            stream_length_reg <= pwdata;
    end

    // Bytes are refused only while the queue is full, so no header is dropped.
    assign in_stall = q_stat.full;
    assign in_fire  = in_valid && !in_stall;

    mahp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .push      (push),
        .push_hdr  (push_hdr)
    );

    mahp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_hdr (push_hdr),
        .pop      (pop),
        .pop_hdr  (pop_hdr),
        .stat     (q_stat)
    );

    mahp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_hdr          (pop_hdr),
        .pop            (pop),
        .stream_length  (stream_length_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .version        (version),
        .layer          (layer),
        .bitrate_kbps   (bitrate_kbps),
        .sample_rate_hz (sample_rate_hz),
        .frame_bytes    (frame_bytes),
        .channel_mode   (channel_mode),
        .copyright_flag (copyright_flag),
        .original_flag  (original_flag),
        .emphasis       (emphasis),
        .frame_count    (frame_count),
        .play_seconds   (play_seconds)
    );

endmodule
